[rtl/core/assert_macros.svh]
// assertion macros shared by the core modules
// expects i_clk and i_rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define CHK_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/bllls_pkg.sv]
// shared types, constants and command structs of the line sampler
// no dependencies
`timescale 1ns / 1ps

package bllls_pkg;

    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_MAX_HEIGHT  = 256;
    localparam int DEF_MAX_SAMPLES = 64;
    localparam int DEF_FRAC_BITS   = 8;

    localparam int COORD_W = 18;
    localparam int CFG_W   = 9;
    localparam int CNT_W   = 7;
    localparam int IDX_W   = 6;
    localparam int LIGHT_W = 16;
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 24;
    localparam int LUMA_W  = 24;

    localparam logic [15:0] W_RED   = 16'd19595;
    localparam logic [15:0] W_GREEN = 16'd38470;
    localparam logic [15:0] W_BLUE  = 16'd7471;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic       wr_pix;
        logic       load;
        logic       fix;
        logic       point;
        logic       weight;
        logic       rd;
        logic       luma;
        logic       mul;
        logic       acc;
        logic       emit;
        logic [1:0] tap;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic oob;
        logic last;
        logic out_free;
    } t_sts;

endpackage

[rtl/core/bllls_in_if.sv]
// input item channel: valid, ready and the pixel / query payload
// depends on bllls_pkg
`timescale 1ns / 1ps

interface bllls_in_if;
    import bllls_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [CHAN_W-1:0]         pixel_col;
    logic [CHAN_W-1:0]         pixel_row;
    logic [CHAN_W-1:0]         blue;
    logic [CHAN_W-1:0]         green;
    logic [CHAN_W-1:0]         red;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [CNT_W-1:0]          sample_count;

    modport source (output valid, operation, pixel_col, pixel_row, blue, green, red,
                    start_x, start_y, end_x, end_y, sample_count, input ready);
    modport sink (input valid, operation, pixel_col, pixel_row, blue, green, red,
                  start_x, start_y, end_x, end_y, sample_count, output ready);
endinterface

[rtl/core/bllls_out_if.sv]
// result channel: valid, ready and one luma sample
// depends on bllls_pkg
`timescale 1ns / 1ps

interface bllls_out_if;
    import bllls_pkg::*;

    logic               valid;
    logic               ready;
    logic [LIGHT_W-1:0] light;
    logic [IDX_W-1:0]   sample_index;
    logic               out_of_bounds;
    logic               last;

    modport source (output valid, light, sample_index, out_of_bounds, last, input ready);
    modport sink (input valid, light, sample_index, out_of_bounds, last, output ready);
endinterface

[rtl/core/bllls_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bllls_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

[rtl/core/bllls_div.sv]
// restoring divider, one quotient bit per cycle, unsigned operands
// no dependencies
`timescale 1ns / 1ps

module bllls_div #(
    parameter int N_W = 19,
    parameter int D_W = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_busy,
    output logic [N_W-1:0] o_quot,
    output logic [D_W-1:0] o_rem
);
    localparam int C_W = $clog2(N_W + 1);

    logic [C_W-1:0] r_cnt;
    logic [N_W-1:0] r_quot;
    logic [D_W-1:0] r_rem;
    logic [D_W-1:0] r_den;
    logic [D_W:0]   trial;
    logic           fits;

    assign trial = {r_rem, r_quot[N_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= C_W'(N_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_cnt != '0) begin
            r_quot <= {r_quot[N_W-2:0], fits};
            r_rem  <= fits ? D_W'(trial - {1'b0, r_den}) : trial[D_W-1:0];
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

[rtl/core/bllls_datapath.sv]
// datapath: config, pixel store, line stepping, bounds test, interpolation, result register
// depends on bllls_pkg, bllls_in_if, bllls_out_if, bllls_ram, bllls_div, assert_macros.svh
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bllls_datapath #(
    parameter int MAX_WIDTH   = bllls_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = bllls_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_SAMPLES = bllls_pkg::DEF_MAX_SAMPLES,
    parameter int FRAC_BITS   = bllls_pkg::DEF_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [bllls_pkg::CFG_W-1:0] i_cfg_data,
    input  bllls_pkg::t_cmd            i_cmd,
    output bllls_pkg::t_sts            o_sts,
    bllls_in_if.sink                   i_item,
    bllls_out_if.source                o_result
);
    import bllls_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int DX_W  = COORD_W + 1;
    localparam int P_W   = COORD_W + 2;
    localparam int I_W   = P_W - FRAC_BITS;
    localparam int WT_W  = 2 * FRAC_BITS + 1;
    localparam int PR_W  = LUMA_W + WT_W;
    localparam int AC_W  = PR_W + 2;
    localparam int RSH   = 8 + 2 * FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [AC_W-1:0]    HALF = AC_W'(1) << (RSH - 1);

    // configuration
    logic [CFG_W-1:0] r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_RESET;
            r_height <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    r_width  <= r_width;
            endcase
        end
    end

    // pixel store
    logic          wr_in_range;
    logic [AW-1:0] waddr, raddr;
    logic [PIX_W-1:0] rdata;

    assign wr_in_range = (int'(i_item.pixel_col) < MAX_WIDTH)
                      && (int'(i_item.pixel_row) < MAX_HEIGHT);
    assign waddr = AW'(int'(i_item.pixel_row) * MAX_WIDTH + int'(i_item.pixel_col));

    bllls_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_pix && wr_in_range),
        .i_waddr (waddr),
        .i_wdata ({i_item.red, i_item.green, i_item.blue}),
        .i_re    (i_cmd.rd),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // query set-up
    logic signed [DX_W-1:0] dx, dy;
    logic [DX_W-1:0]        magx, magy;
    logic [CNT_W-1:0]       n_cnt;
    logic [IDX_W-1:0]       n_den;

    assign dx   = DX_W'(i_item.end_x) - DX_W'(i_item.start_x);
    assign dy   = DX_W'(i_item.end_y) - DX_W'(i_item.start_y);
    assign magx = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
    assign magy = dy[DX_W-1] ? DX_W'(-dy) : DX_W'(dy);

    always_comb begin
        priority if (i_item.sample_count == '0) begin
            n_cnt = CNT_W'(1);
        end else if (int'(i_item.sample_count) > MAX_SAMPLES) begin
            n_cnt = CNT_W'(MAX_SAMPLES);
        end else begin
            n_cnt = i_item.sample_count;
        end
    end
    assign n_den = IDX_W'(n_cnt - 1'b1);

    logic signed [COORD_W-1:0] r_sx, r_sy;
    logic [IDX_W-1:0]          r_den;
    logic                      r_negx, r_negy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_den <= '0;
        end else if (i_cmd.load) begin
            r_den <= n_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx   <= i_item.start_x;
            r_sy   <= i_item.start_y;
            r_negx <= dx[DX_W-1];
            r_negy <= dy[DX_W-1];
        end
    end

    logic             busy_x, busy_y;
    logic [DX_W-1:0]  quot_x, quot_y;
    logic [IDX_W-1:0] rem_x, rem_y;

    bllls_div #(.N_W(DX_W), .D_W(IDX_W)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.load), .i_num(magx),
        .i_den(n_den), .o_busy(busy_x), .o_quot(quot_x), .o_rem(rem_x)
    );

    bllls_div #(.N_W(DX_W), .D_W(IDX_W)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.load), .i_num(magy),
        .i_den(n_den), .o_busy(busy_y), .o_quot(quot_y), .o_rem(rem_y)
    );

    // floor quotient and remainder of the per-step increment
    logic signed [P_W-1:0] n_qdx, n_qdy;
    logic [IDX_W-1:0]      n_rdx, n_rdy;

    always_comb begin
        n_qdx = P_W'(quot_x);
        n_rdx = rem_x;
        if (r_den == '0) begin
            n_qdx = '0;
            n_rdx = '0;
        end else if (r_negx && rem_x != '0) begin
            n_qdx = -P_W'(quot_x) - P_W'(1);
            n_rdx = r_den - rem_x;
        end else if (r_negx) begin
            n_qdx = -P_W'(quot_x);
        end
        n_qdy = P_W'(quot_y);
        n_rdy = rem_y;
        if (r_den == '0) begin
            n_qdy = '0;
            n_rdy = '0;
        end else if (r_negy && rem_y != '0) begin
            n_qdy = -P_W'(quot_y) - P_W'(1);
            n_rdy = r_den - rem_y;
        end else if (r_negy) begin
            n_qdy = -P_W'(quot_y);
        end
    end

    logic signed [P_W-1:0] r_qdx, r_qdy, r_qx, r_qy;
    logic [IDX_W-1:0]      r_rdx, r_rdy, r_rx, r_ry, r_idx;
    logic [IDX_W:0]        sum_rx, sum_ry;
    logic                  wrap_x, wrap_y;

    assign sum_rx = {1'b0, r_rx} + {1'b0, r_rdx};
    assign sum_ry = {1'b0, r_ry} + {1'b0, r_rdy};
    assign wrap_x = (r_den != '0) && (sum_rx >= {1'b0, r_den});
    assign wrap_y = (r_den != '0) && (sum_ry >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_cmd.fix) begin
            r_qdx <= n_qdx;
            r_qdy <= n_qdy;
            r_rdx <= n_rdx;
            r_rdy <= n_rdy;
        end
        if (i_cmd.load) begin
            r_qx  <= '0;
            r_qy  <= '0;
            r_rx  <= '0;
            r_ry  <= '0;
            r_idx <= '0;
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + 1'b1;
            r_qx  <= r_qx + r_qdx + (wrap_x ? P_W'(1) : P_W'(0));
            r_qy  <= r_qy + r_qdy + (wrap_y ? P_W'(1) : P_W'(0));
            r_rx  <= wrap_x ? IDX_W'(sum_rx - {1'b0, r_den}) : sum_rx[IDX_W-1:0];
            r_ry  <= wrap_y ? IDX_W'(sum_ry - {1'b0, r_den}) : sum_ry[IDX_W-1:0];
        end
    end

    // sample point and bounds test
    logic signed [P_W-1:0] px, py;
    logic [I_W-1:0]        n_ix, n_iy;
    int                    w_eff, h_eff;
    logic                  n_oob;

    assign px    = P_W'(r_sx) + r_qx;
    assign py    = P_W'(r_sy) + r_qy;
    assign n_ix  = px[P_W-1:FRAC_BITS];
    assign n_iy  = py[P_W-1:FRAC_BITS];
    assign w_eff = (int'(r_width) > MAX_WIDTH) ? MAX_WIDTH : int'(r_width);
    assign h_eff = (int'(r_height) > MAX_HEIGHT) ? MAX_HEIGHT : int'(r_height);
    assign n_oob = px[P_W-1] || py[P_W-1] || (int'(n_ix) + 1 >= w_eff)
                || (int'(n_iy) + 1 >= h_eff);

    logic [I_W-1:0]       r_ix, r_iy;
    logic [FRAC_BITS-1:0] r_fx, r_fy;
    logic                 r_oob;

    always_ff @(posedge i_clk) begin
        if (i_cmd.point) begin
            r_ix  <= n_ix;
            r_iy  <= n_iy;
            r_fx  <= px[FRAC_BITS-1:0];
            r_fy  <= py[FRAC_BITS-1:0];
            r_oob <= n_oob;
        end
    end

    // corner weights
    logic [FRAC_BITS:0] wx0, wx1, wy0, wy1;
    logic [WT_W-1:0]    r_wt [4];

    assign wx0 = ONE - {1'b0, r_fx};
    assign wx1 = {1'b0, r_fx};
    assign wy0 = ONE - {1'b0, r_fy};
    assign wy1 = {1'b0, r_fy};

    always_ff @(posedge i_clk) begin
        if (i_cmd.weight) begin
            r_wt[0] <= WT_W'(wx0 * wy0);
            r_wt[1] <= WT_W'(wx1 * wy0);
            r_wt[2] <= WT_W'(wx0 * wy1);
            r_wt[3] <= WT_W'(wx1 * wy1);
        end
    end

    assign raddr = AW'((int'(r_iy) + int'(i_cmd.tap[1])) * MAX_WIDTH
                 + int'(r_ix) + int'(i_cmd.tap[0]));

    // luma, weighting and accumulation
    logic [LUMA_W-1:0] r_luma;
    logic [PR_W-1:0]   r_prod;
    logic [AC_W-1:0]   r_acc;
    logic [LUMA_W+1:0] n_luma;

    assign n_luma = (LUMA_W + 2)'(rdata[23:16] * W_RED)
                  + (LUMA_W + 2)'(rdata[15:8] * W_GREEN)
                  + (LUMA_W + 2)'(rdata[7:0] * W_BLUE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.luma) begin
            r_luma <= n_luma[LUMA_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= PR_W'(r_luma * r_wt[i_cmd.tap]);
        end
        if (i_cmd.point) begin
            r_acc <= '0;
        end else if (i_cmd.acc) begin
            r_acc <= r_acc + AC_W'(r_prod);
        end
    end

    // result register
    logic [AC_W-1:0] rounded;
    logic            r_out_valid;

    assign rounded = (r_acc + HALF) >> RSH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_result.light         <= r_oob ? '0 : LIGHT_W'(rounded);
            o_result.sample_index  <= r_idx;
            o_result.out_of_bounds <= r_oob;
            o_result.last          <= r_idx == r_den;
        end
    end

    assign o_result.valid = r_out_valid;

    assign o_sts.div_busy = busy_x || busy_y;
    assign o_sts.oob      = r_oob;
    assign o_sts.last     = r_idx == r_den;
    assign o_sts.out_free = !r_out_valid || o_result.ready;

    `CHK_NEVER(a_rem_range, (r_den != '0) && ((r_rx >= r_den) || (r_ry >= r_den)), "step remainder out of range")
    `CHK_NEVER(a_emit_blocked, i_cmd.emit && r_out_valid && !o_result.ready, "result overwritten before transfer")
endmodule

[rtl/core/bllls_ctrl.sv]
// controller: sequences pixel writes, line set-up and per-sample interpolation
// depends on bllls_pkg, assert_macros.svh
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bllls_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_op,
    output logic            o_in_ready,
    input  bllls_pkg::t_sts i_sts,
    output bllls_pkg::t_cmd o_cmd
);
    import bllls_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DIV    = 9'b000000010,
        S_POINT  = 9'b000000100,
        S_WEIGHT = 9'b000001000,
        S_RD     = 9'b000010000,
        S_LUMA   = 9'b000100000,
        S_MUL    = 9'b001000000,
        S_ACC    = 9'b010000000,
        S_EMIT   = 9'b100000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_tap, n_tap;
    logic       accept;

    assign o_in_ready = r_state == S_IDLE;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        o_cmd   = '0;
        o_cmd.tap = r_tap;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_in_op == OP_SAMPLE) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end else if (accept) begin
                    o_cmd.wr_pix = 1'b1;
                end
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.fix = 1'b1;
                    n_state   = S_POINT;
                end
            end
            S_POINT: begin
                o_cmd.point = 1'b1;
                n_state     = S_WEIGHT;
            end
            S_WEIGHT: begin
                o_cmd.weight = 1'b1;
                n_tap        = '0;
                n_state      = i_sts.oob ? S_EMIT : S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LUMA;
            end
            S_LUMA: begin
                o_cmd.luma = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_tap     = r_tap + 1'b1;
                n_state   = (r_tap == 2'd3) ? S_EMIT : S_RD;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.last ? S_IDLE : S_POINT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

    `CHK_ASSERT(a_last_to_idle, (r_state == S_EMIT) && i_sts.out_free && i_sts.last |=> r_state == S_IDLE, "last sample did not end the query")
    `CHK_NEVER(a_ready_busy, o_in_ready && i_sts.div_busy, "input taken while divider busy")
    `CHK_ASSERT(a_four_taps, (r_state == S_ACC) && (r_tap == 2'd3) |=> r_state == S_EMIT, "corner sequence did not close")
endmodule

[rtl/core/bilinear_luma_line_sampler_unit.sv]
// top level of the bilinear luma line sampler
// depends on bllls_pkg, bllls_in_if, bllls_out_if, bllls_ctrl, bllls_datapath
`timescale 1ns / 1ps

// Loads a BGR image one pixel per transfer and walks a line between two Q9.8
// points, giving one bilinear BT.601 luma sample (Q8.8) per point with a last
// marker and an out-of-bounds flag. Pixel writes are taken back to back while
// idle. A line query starts with a set-up in the bit-serial divider that splits the
// line step into quotient and remainder; then each in-bounds sample makes
// four corner reads through the single read port of the pixel store, each read,
// weighted and summed in turn, and an out-of-bounds sample skips the reads. A new item
// is taken once the last sample of a query is in the result register. The pixel
// store is not cleared at reset: read only pixels that were written.
module bilinear_luma_line_sampler_unit #(
    parameter int MAX_WIDTH   = bllls_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = bllls_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_SAMPLES = bllls_pkg::DEF_MAX_SAMPLES,
    parameter int FRAC_BITS   = bllls_pkg::DEF_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [bllls_pkg::CFG_W-1:0] i_cfg_data,
    bllls_in_if.sink                    i_item,
    bllls_out_if.source                 o_result
);
    import bllls_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic ready;

    assign i_item.ready = ready;

    bllls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_op    (i_item.operation),
        .o_in_ready (ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bllls_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_SAMPLES (MAX_SAMPLES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_item      (i_item),
        .o_result    (o_result)
    );
endmodule

[tb/tb_top.sv]
// self-checking testbench of the bilinear luma line sampler: pixel loads, line queries
// depends on bllls_pkg, bllls_in_if, bllls_out_if and bilinear_luma_line_sampler_unit
`timescale 1ns / 1ps

module tb_top;
    import bllls_pkg::*;

    localparam int  IMG_DIM    = 256;
    localparam int  FB         = 8;
    localparam int  ONE        = 1 << FB;
    localparam int  LOAD_DIM   = 13;
    localparam longint LIMIT   = 2000000;

    typedef struct {
        t_op                       op;
        logic [CHAN_W-1:0]         col, row, blue, green, red;
        logic signed [COORD_W-1:0] sx, sy, ex, ey;
        logic [CNT_W-1:0]          cnt;
    } pix_cmd_t;

    typedef struct {
        logic [LIGHT_W-1:0] light;
        logic [IDX_W-1:0]   idx;
        logic               oob;
        logic               last;
    } luma_sample_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = CFG_WIDTH;
    logic [CFG_W-1:0] i_cfg_data = '0;

    bllls_in_if  item_if ();
    bllls_out_if res_if ();

    bilinear_luma_line_sampler_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (item_if.sink),
        .o_result    (res_if.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    pix_cmd_t     pending_cmds[$];
    luma_sample_t expected_samples[$];
    logic [PIX_W-1:0] image_mem [0:IMG_DIM*IMG_DIM-1];
    bit           loaded [0:IMG_DIM*IMG_DIM-1];
    int           cur_width = 256, cur_height = 256;
    int           idle_pct = 0, stall_pct = 0;
    int           queued_cnt = 0, accepted_cnt = 0;
    int           n_queries = 0, n_samples = 0, n_oob = 0, n_errors = 0;
    longint       cycles = 0;
    pix_cmd_t     drv_cmd;

    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if (num < 0 && q * den != num) q -= 1;
        return q;
    endfunction

    function automatic longint pixel_luma(int x, int y);
        logic [PIX_W-1:0] p;
        p = image_mem[y * IMG_DIM + x];
        return longint'(p[23:16]) * W_RED + longint'(p[15:8]) * W_GREEN
             + longint'(p[7:0]) * W_BLUE;
    endfunction

    // walks the line; returns 0 if an in-bounds point would touch an unloaded pixel,
    // and with commit set queues the expected samples
    function automatic bit walk_line(pix_cmd_t c, bit commit);
        longint sx, sy, dx, dy, px, py, fx, fy, up, down, acc;
        int n, w, h, ix, iy;
        bit inb, safe;
        luma_sample_t s;
        safe = 1'b1;
        sx = longint'(c.sx);
        sy = longint'(c.sy);
        dx = longint'(c.ex) - sx;
        dy = longint'(c.ey) - sy;
        n = int'(c.cnt);
        if (n == 0) n = 1;
        if (n > DEF_MAX_SAMPLES) n = DEF_MAX_SAMPLES;
        w = cur_width > IMG_DIM ? IMG_DIM : cur_width;
        h = cur_height > IMG_DIM ? IMG_DIM : cur_height;
        for (int i = 0; i < n; i++) begin
            px = sx;
            py = sy;
            if (n > 1) begin
                px += floor_quot(dx * i, n - 1);
                py += floor_quot(dy * i, n - 1);
            end
            inb = px >= 0 && py >= 0 && px + ONE < longint'(w) * ONE
                  && py + ONE < longint'(h) * ONE;
            acc = 0;
            if (inb) begin
                ix = int'(px >>> FB);
                iy = int'(py >>> FB);
                fx = px & (ONE - 1);
                fy = py & (ONE - 1);
                if (!loaded[iy*IMG_DIM+ix] || !loaded[iy*IMG_DIM+ix+1]
                    || !loaded[(iy+1)*IMG_DIM+ix] || !loaded[(iy+1)*IMG_DIM+ix+1])
                    safe = 1'b0;
                if (commit) begin
                    up   = pixel_luma(ix, iy) * (ONE - fx) + pixel_luma(ix + 1, iy) * fx;
                    down = pixel_luma(ix, iy + 1) * (ONE - fx)
                         + pixel_luma(ix + 1, iy + 1) * fx;
                    acc  = (up * (ONE - fy) + down * fy + (longint'(1) << (7 + 2*FB)))
                           >> (8 + 2*FB);
                end
            end
            if (commit) begin
                s.light = acc[LIGHT_W-1:0];
                s.idx   = i[IDX_W-1:0];
                s.oob   = !inb;
                s.last  = (i + 1 == n);
                expected_samples.push_back(s);
            end
        end
        return safe;
    endfunction

    task automatic queue_pixel(int col, int row);
        pix_cmd_t c;
        c.op = OP_WRITE;
        c.col = col[7:0];
        c.row = row[7:0];
        c.blue = CHAN_W'($urandom);
        c.green = CHAN_W'($urandom);
        c.red = CHAN_W'($urandom);
        c.sx = COORD_W'($urandom);
        c.sy = COORD_W'($urandom);
        c.ex = COORD_W'($urandom);
        c.ey = COORD_W'($urandom);
        c.cnt = CNT_W'($urandom);
        loaded[row*IMG_DIM+col] = 1'b1;
        pending_cmds.push_back(c);
        queued_cnt++;
    endtask

    task automatic queue_line(int sx, int sy, int ex, int ey, int cnt);
        pix_cmd_t c;
        c.op = OP_SAMPLE;
        c.col = CHAN_W'($urandom);
        c.row = CHAN_W'($urandom);
        c.blue = CHAN_W'($urandom);
        c.green = CHAN_W'($urandom);
        c.red = CHAN_W'($urandom);
        c.sx = COORD_W'(sx);
        c.sy = COORD_W'(sy);
        c.ex = COORD_W'(ex);
        c.ey = COORD_W'(ey);
        c.cnt = CNT_W'(cnt);
        if (walk_line(c, 1'b0)) begin
            pending_cmds.push_back(c);
            queued_cnt++;
        end
    endtask

    // random query retried until every in-bounds point reads loaded pixels
    task automatic queue_random_line();
        int q0, cnt;
        q0 = queued_cnt;
        while (queued_cnt == q0) begin
            cnt = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(16);
            if ($urandom_range(99) < 85)
                queue_line($urandom_range(16*ONE) - ONE, $urandom_range(16*ONE) - ONE,
                           $urandom_range(16*ONE) - ONE, $urandom_range(16*ONE) - ONE, cnt);
            else
                queue_line($urandom_range(262143) - 131072, $urandom_range(262143) - 131072,
                           $urandom_range(262143) - 131072, $urandom_range(262143) - 131072,
                           cnt);
        end
    endtask

    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // item driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else if (!item_if.valid || item_if.ready) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
                drv_cmd = pending_cmds.pop_front();
                item_if.valid        <= 1'b1;
                item_if.operation    <= drv_cmd.op;
                item_if.pixel_col    <= drv_cmd.col;
                item_if.pixel_row    <= drv_cmd.row;
                item_if.blue         <= drv_cmd.blue;
                item_if.green        <= drv_cmd.green;
                item_if.red          <= drv_cmd.red;
                item_if.start_x      <= drv_cmd.sx;
                item_if.start_y      <= drv_cmd.sy;
                item_if.end_x        <= drv_cmd.ex;
                item_if.end_y        <= drv_cmd.ey;
                item_if.sample_count <= drv_cmd.cnt;
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        res_if.ready <= i_rst_n && ($urandom_range(99) >= stall_pct);
    end

    // monitor: predict on each accepted item, check each result transfer
    always @(posedge i_clk) begin
        pix_cmd_t c;
        luma_sample_t e;
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end else if (i_rst_n) begin
            if (item_if.valid && item_if.ready) begin
                accepted_cnt++;
                c.op  = t_op'(item_if.operation);
                c.col = item_if.pixel_col;
                c.row = item_if.pixel_row;
                c.sx  = item_if.start_x;
                c.sy  = item_if.start_y;
                c.ex  = item_if.end_x;
                c.ey  = item_if.end_y;
                c.cnt = item_if.sample_count;
                if (c.op == OP_WRITE) begin
                    image_mem[c.row*IMG_DIM+c.col] =
                        {item_if.red, item_if.green, item_if.blue};
                end else begin
                    n_queries++;
                    void'(walk_line(c, 1'b1));
                end
            end
            if (res_if.valid && res_if.ready) begin
                n_samples++;
                if (res_if.out_of_bounds) n_oob++;
                if (expected_samples.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected sample: light %h idx %0d", res_if.light,
                                 res_if.sample_index);
                end else begin
                    e = expected_samples.pop_front();
                    if (res_if.light !== e.light || res_if.sample_index !== e.idx
                        || res_if.out_of_bounds !== e.oob || res_if.last !== e.last) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("mismatch: exp light %h idx %0d oob %b last %b, got %h %0d %b %b",
                                     e.light, e.idx, e.oob, e.last, res_if.light,
                                     res_if.sample_index, res_if.out_of_bounds, res_if.last);
                    end
                end
            end
        end
    end

    int cfg_w [8] = '{256, 13, 511, 0, 1, 13, 256, 12};
    int cfg_h [8] = '{256, 13, 300, 5, 256, 2, 1, 12};
    int idle_tab  [4] = '{0, 65, 0, 29};
    int stall_tab [4] = '{0, 0, 65, 29};

    initial begin
        item_if.valid = 1'b0;
        item_if.operation = OP_WRITE;
        item_if.pixel_col = '0;
        item_if.pixel_row = '0;
        item_if.blue = '0;
        item_if.green = '0;
        item_if.red = '0;
        item_if.start_x = '0;
        item_if.start_y = '0;
        item_if.end_x = '0;
        item_if.end_y = '0;
        item_if.sample_count = '0;
        res_if.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < 8; p++) begin
            if (p > 0) begin
                wait_drained();
                write_reg(CFG_WIDTH, cfg_w[p]);
                write_reg(CFG_HEIGHT, cfg_h[p]);
                cur_width  = cfg_w[p];
                cur_height = cfg_h[p];
            end
            idle_pct  = idle_tab[p % 4];
            stall_pct = stall_tab[p % 4];
            if (p == 0) begin
                for (int r = 0; r < LOAD_DIM; r++)
                    for (int c = 0; c < LOAD_DIM; c++)
                        queue_pixel(c, r);
                queue_pixel(255, 255);
                queue_pixel(0, 255);
                queue_line(ONE + 128, ONE + 128, 0, 0, 0);
                queue_line(0, 0, 5*ONE, 5*ONE, 1);
                queue_line(0, 0, 11*ONE + 255, 11*ONE + 255, 64);
                queue_line(12*ONE - 1, 11*ONE, 0, 3*ONE + 7, 7);
                queue_line(131071, 131071, -131072, -131072, 127);
                queue_line(-131072, 3*ONE, 131071, 3*ONE, 5);
                queue_line(-1, -1, 2*ONE, -5, 3);
            end
            for (int k = 0; k < 18; k++) begin
                if (p == 2 && k == 15) wait_drained();
                if ($urandom_range(99) < 30) begin
                    if ($urandom_range(1))
                        queue_pixel($urandom_range(255), $urandom_range(255));
                    else
                        queue_pixel($urandom_range(LOAD_DIM-1), $urandom_range(LOAD_DIM-1));
                end else begin
                    queue_random_line();
                end
            end
        end
        wait_drained();

        $display("%0d items, %0d line queries, %0d samples (%0d out of bounds) over 8 settings",
                 accepted_cnt, n_queries, n_samples, n_oob);
        $display("%0d mismatches", n_errors);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/bllls_pkg.sv
rtl/core/bllls_in_if.sv
rtl/core/bllls_out_if.sv
rtl/core/bllls_ram.sv
rtl/core/bllls_div.sv
rtl/core/bllls_datapath.sv
rtl/core/bllls_ctrl.sv
rtl/core/bilinear_luma_line_sampler_unit.sv
tb/tb_top.sv
